/* design/mcpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpd_pkg
// Shared types and constants of the multi-channel poll debouncer.
// ----------------------------------------------------------------------------
package mcpd_pkg;

  localparam int MAX_CH       = 3;
  localparam int NUM_CHANNELS = 3;
  localparam int CNT_W        = 8;
  localparam int TICK_W       = 10;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 10;

  localparam logic [MAX_CH-1:0] ENABLE_RST = 3'd3;
  localparam logic [CNT_W-1:0]  STABLE_COUNT_RST [MAX_CH] = '{8'd3, 8'd10, 8'd10};
  localparam logic [TICK_W-1:0] POLL_TICKS_RST   [MAX_CH] = '{10'd11, 10'd76, 10'd16};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_ENABLE   = 8'd0,
    CFG_STABLE_COUNT_CH0 = 8'd1,
    CFG_STABLE_COUNT_CH1 = 8'd2,
    CFG_STABLE_COUNT_CH2 = 8'd3,
    CFG_POLL_TICKS_CH0   = 8'd4,
    CFG_POLL_TICKS_CH1   = 8'd5,
    CFG_POLL_TICKS_CH2   = 8'd6
  } cfg_reg_t;

  typedef struct packed {
    logic              enable;
    logic [CNT_W-1:0]  stable_count;
    logic [TICK_W-1:0] poll_ticks;
  } lane_cfg_t;

  typedef struct packed {
    logic started;
    logic done;
    logic level;
  } lane_result_t;

endpackage

/* design/mcpd_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpd_lane
// One channel: trigger detect, poll timer, match counter and accept compare.
// ----------------------------------------------------------------------------
module mcpd_lane (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick,
  input  mcpd_pkg::lane_cfg_t    cfg,
  input  logic                   sense,
  input  logic                   irq,
  output mcpd_pkg::lane_result_t result
);

  logic [mcpd_pkg::CNT_W-1:0]  match_count, match_count_next;
  logic                        last_level, last_level_next;
  logic                        last_valid, last_valid_next;
  logic [mcpd_pkg::TICK_W-1:0] poll_timer, poll_timer_next;
  logic                        busy, busy_next;
  logic                        kickoff, kickoff_next;

  logic [mcpd_pkg::CNT_W-1:0]  target;
  logic [mcpd_pkg::TICK_W-1:0] period;
  logic [mcpd_pkg::CNT_W-1:0]  count_new;
  logic                        counting, expired, sample, matched, reached;

  // zero settings behave as one
  assign target = (cfg.stable_count == '0) ? mcpd_pkg::CNT_W'(1) : cfg.stable_count;
  assign period = (cfg.poll_ticks == '0) ? mcpd_pkg::TICK_W'(1) : cfg.poll_ticks;

  assign counting  = busy && (poll_timer != '0);
  assign expired   = counting && (poll_timer == mcpd_pkg::TICK_W'(1));
  assign sample    = cfg.enable && (expired || kickoff || (!busy && irq));
  assign matched   = last_valid && (sense == last_level) && (match_count < target);
  assign count_new = matched ? match_count + mcpd_pkg::CNT_W'(1) : mcpd_pkg::CNT_W'(1);
  assign reached   = count_new >= target;

  assign result.started = sample && (match_count == '0);
  assign result.done    = sample && reached;
  assign result.level   = sample && reached && sense;

  always_comb begin
    match_count_next = match_count;
    last_level_next  = last_level;
    last_valid_next  = last_valid;
    poll_timer_next  = poll_timer;
    busy_next        = busy;
    kickoff_next     = kickoff;
    if (tick && cfg.enable) begin
      if (counting) begin
        poll_timer_next = poll_timer - mcpd_pkg::TICK_W'(1);
      end
      if (sample) begin
        kickoff_next = 1'b0;
        if (reached) begin
          match_count_next = '0;
          last_level_next  = 1'b0;
          last_valid_next  = 1'b0;
          busy_next        = 1'b0;
          poll_timer_next  = '0;
        end else begin
          match_count_next = count_new;
          last_level_next  = sense;
          last_valid_next  = 1'b1;
          busy_next        = 1'b1;
          poll_timer_next  = period;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_count <= '0;
      last_level  <= 1'b0;
      last_valid  <= 1'b0;
      poll_timer  <= '0;
      busy        <= 1'b0;
      kickoff     <= 1'b1;
    end else begin
      match_count <= match_count_next;
      last_level  <= last_level_next;
      last_valid  <= last_valid_next;
      poll_timer  <= poll_timer_next;
      busy        <= busy_next;
      kickoff     <= kickoff_next;
    end
  end

endmodule

/* design/mcpd_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpd_merge
// Gathers the lane results into masks and holds them in the output register.
// ----------------------------------------------------------------------------
module mcpd_merge (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              tick,
  input  mcpd_pkg::lane_result_t            lane_res [mcpd_pkg::MAX_CH],
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mcpd_pkg::MAX_CH-1:0]       started_mask,
  output logic [mcpd_pkg::MAX_CH-1:0]       done_mask,
  output logic [mcpd_pkg::MAX_CH-1:0]       stable_levels
);

  logic [mcpd_pkg::MAX_CH-1:0] started_in, done_in, level_in;
  logic                        drain;

  always_comb begin
    for (int n = 0; n < mcpd_pkg::MAX_CH; n++) begin
      started_in[n] = lane_res[n].started;
      done_in[n]    = lane_res[n].done;
      level_in[n]   = lane_res[n].level;
    end
  end

  assign drain = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick) begin
      out_valid <= 1'b1;
    end else if (drain) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      started_mask  <= started_in;
      done_mask     <= done_in;
      stable_levels <= level_in;
    end
  end

endmodule

/* design/multi_channel_poll_debouncer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_poll_debouncer
// Three-channel switch debouncer driven by a millisecond tick word.
// ----------------------------------------------------------------------------
// Every accepted input word is one tick carrying the raw sense level and the
// interrupt flag of each channel; every tick produces exactly one result word
// with the started, done and accepted-level masks. One lane per channel holds
// its match counter and poll timer, so a new tick is taken every clock while input
// stall is low; the result appears in the output register in the cycle after
// acceptance, and input stall is raised only while that register is full and
// stalled. Configuration writes are taken at any time (ready is always high) and
// are meant to be issued while no tick is in flight.
module multi_channel_poll_debouncer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mcpd_pkg::MAX_CH-1:0]         sense_levels,
  input  logic [mcpd_pkg::MAX_CH-1:0]         irq_flags,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mcpd_pkg::MAX_CH-1:0]         started_mask,
  output logic [mcpd_pkg::MAX_CH-1:0]         done_mask,
  output logic [mcpd_pkg::MAX_CH-1:0]         stable_levels,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mcpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mcpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [mcpd_pkg::MAX_CH-1:0] channel_enable;
  logic [mcpd_pkg::CNT_W-1:0]  stable_count [mcpd_pkg::MAX_CH];
  logic [mcpd_pkg::TICK_W-1:0] poll_ticks   [mcpd_pkg::MAX_CH];

  mcpd_pkg::lane_result_t lane_res [mcpd_pkg::MAX_CH];
  logic                   tick;
  logic                   cfg_write;

  assign in_stall  = out_valid && out_stall;
  assign tick      = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable <= mcpd_pkg::ENABLE_RST;
      stable_count   <= mcpd_pkg::STABLE_COUNT_RST;
      poll_ticks     <= mcpd_pkg::POLL_TICKS_RST;
    end else if (cfg_write) begin
      case (mcpd_pkg::cfg_reg_t'(cfg_index))
        mcpd_pkg::CFG_CHANNEL_ENABLE:
          channel_enable <= cfg_data[mcpd_pkg::MAX_CH-1:0];
        mcpd_pkg::CFG_STABLE_COUNT_CH0: stable_count[0] <= cfg_data[mcpd_pkg::CNT_W-1:0];
        mcpd_pkg::CFG_STABLE_COUNT_CH1: stable_count[1] <= cfg_data[mcpd_pkg::CNT_W-1:0];
        mcpd_pkg::CFG_STABLE_COUNT_CH2: stable_count[2] <= cfg_data[mcpd_pkg::CNT_W-1:0];
        mcpd_pkg::CFG_POLL_TICKS_CH0:   poll_ticks[0]   <= cfg_data[mcpd_pkg::TICK_W-1:0];
        mcpd_pkg::CFG_POLL_TICKS_CH1:   poll_ticks[1]   <= cfg_data[mcpd_pkg::TICK_W-1:0];
        mcpd_pkg::CFG_POLL_TICKS_CH2:   poll_ticks[2]   <= cfg_data[mcpd_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar n = 0; n < mcpd_pkg::MAX_CH; n++) begin : g_lane
    if (n < mcpd_pkg::NUM_CHANNELS) begin : g_on
      mcpd_pkg::lane_cfg_t lane_cfg;
      assign lane_cfg.enable       = channel_enable[n];
      assign lane_cfg.stable_count = stable_count[n];
      assign lane_cfg.poll_ticks   = poll_ticks[n];

      mcpd_lane u_lane (
        .clk    (clk),
        .rst    (rst),
        .tick   (tick),
        .cfg    (lane_cfg),
        .sense  (sense_levels[n]),
        .irq    (irq_flags[n]),
        .result (lane_res[n])
      );
    end else begin : g_off
      // channels past the configured count stay silent
      assign lane_res[n] = '0;
    end
  end

  mcpd_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick),
    .lane_res      (lane_res),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .started_mask  (started_mask),
    .done_mask     (done_mask),
    .stable_levels (stable_levels)
  );

  logic [mcpd_pkg::MAX_CH-1:0] lane_active;
  always_comb begin
    for (int n = 0; n < mcpd_pkg::MAX_CH; n++) begin
      lane_active[n] = lane_res[n].started | lane_res[n].done;
    end
  end

  a_level_only_when_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((stable_levels & ~done_mask) == '0))
    else $error("accepted level set on a channel that did not finish");

  a_tick_gives_word: assert property (@(posedge clk) disable iff (rst)
    tick |=> out_valid)
    else $error("accepted tick produced no result word");

  a_disabled_lane_quiet: assert property (@(posedge clk) disable iff (rst)
    tick |-> ((lane_active & ~channel_enable) == '0))
    else $error("disabled channel reported activity");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !tick) |=> !out_valid)
    else $error("result word repeated after being taken");

endmodule
